// File: hdl/ntac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ntac_pkg;

    // Command codes carried in the action field.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_ERASE = 2'd2;

    // Result error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NOT_READY = 2'd1;
    localparam logic [1:0] ERR_BAD_PARAM = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PAGE_BYTES       = 3'd0;
    localparam logic [2:0] CFG_PAGES_PER_BLOCK  = 3'd1;
    localparam logic [2:0] CFG_BLOCKS_PER_PLANE = 3'd2;
    localparam logic [2:0] CFG_BLOCK_COUNT      = 3'd3;
    localparam logic [2:0] CFG_PLANE_COUNT      = 3'd4;
    localparam logic [2:0] CFG_DEVICE_READY     = 3'd5;

    localparam int unsigned CFG_DATA_BITS = 17;
    localparam int unsigned WORD_BITS     = 32;

    // Sideband that travels beside the divider data through every cell.
    typedef struct packed {
        logic [1:0]  action;
        logic        rw_range_ok;
        logic        er_range_ok;
        logic        size_zero;
        logic        addr_aligned;
        logic        size_aligned;
        logic        block_ok;
        logic [31:0] size;
        logic [31:0] page;
        logic [31:0] total;
        logic [9:0]  page_in_block;
    } t_side;

endpackage

`default_nettype wire

// File: hdl/ntac_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ntac_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] byte_address;
    logic [31:0] byte_count;

    modport source (output valid, action, byte_address, byte_count, input ready);
    modport sink (input valid, action, byte_address, byte_count, output ready);
endinterface

`default_nettype wire

// File: hdl/ntac_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ntac_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  error_code;
    logic [9:0]  page_in_block;
    logic [15:0] block_in_plane;
    logic [3:0]  plane_index;
    logic [31:0] page_total;

    modport source (output valid, accepted, error_code, page_in_block, block_in_plane,
                    plane_index, page_total, input ready);
    modport sink (input valid, accepted, error_code, page_in_block, block_in_plane,
                  plane_index, page_total, output ready);
endinterface

`default_nettype wire

// File: hdl/nand_transfer_address_check.sv
`timescale 1ns / 1ps
`default_nettype none

// NAND transfer address check.
// A command transfer on cmd carries an action (read, write or erase block), a
// linear byte address and a byte count. For each command exactly one result
// transfer leaves on res: accepted, an error code, and the address split into
// page in block, block in plane and plane, plus the page count for read and
// write. The geometry is set through the write port i_cfg_we / i_cfg_index /
// i_cfg_data and must only change while no command is in flight.
// From command to result a command passes one input register, four chains
// of 32 restoring division cells (address by page size, count by page size,
// page by pages per block, block by blocks per plane) and one output
// register. The cells hand their data forward every cycle, so a new command
// is taken every cycle, one command per clock, while no stall backs it up.
// Each cell has its own valid bit and can hold while its successor is full,
// so a stalled receiver only blocks the pipeline once every cell is occupied;
// until then commands keep entering behind the waiting result.
// Synchronous reset empties the pipeline and clears all geometry registers,
// which makes every command fail with device not ready until configured.
// The device size product follows a configuration write through r_block_bytes and r_dev_bytes.
module nand_transfer_address_check #(
    parameter int unsigned ADDRESS_BITS = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    ntac_cmd_if.sink                                  cmd,
    ntac_res_if.source                                res,
    input  wire logic                                 i_cfg_we,
    input  wire logic [2:0]                           i_cfg_index,
    input  wire logic [ntac_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    // Values are masked to the low ADDRESS_BITS bits; the fields are 32 wide.
    localparam logic [63:0] AMASK64 = (64'd1 << ADDRESS_BITS) - 64'd1;
    localparam logic [31:0] AMASK   = AMASK64[31:0];
    localparam int unsigned SW      = $bits(ntac_pkg::t_side);

    // Geometry registers.
    logic [16:0] r_page_bytes;
    logic [10:0] r_pages_per_block;
    logic [15:0] r_blocks_per_plane;
    logic [15:0] r_block_count;
    logic [4:0]  r_plane_count;
    logic        r_device_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes       <= '0;
            r_pages_per_block  <= '0;
            r_blocks_per_plane <= '0;
            r_block_count      <= '0;
            r_plane_count      <= '0;
            r_device_ready     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ntac_pkg::CFG_PAGE_BYTES:       r_page_bytes       <= i_cfg_data;
                ntac_pkg::CFG_PAGES_PER_BLOCK:  r_pages_per_block  <= i_cfg_data[10:0];
                ntac_pkg::CFG_BLOCKS_PER_PLANE: r_blocks_per_plane <= i_cfg_data[15:0];
                ntac_pkg::CFG_BLOCK_COUNT:      r_block_count      <= i_cfg_data[15:0];
                ntac_pkg::CFG_PLANE_COUNT:      r_plane_count      <= i_cfg_data[4:0];
                ntac_pkg::CFG_DEVICE_READY:     r_device_ready     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Device size, exact in 44 bits, built over two registered multiplies.
    logic [27:0] r_block_bytes;
    logic [43:0] r_dev_bytes;

    always_ff @(posedge i_clk) begin
        r_block_bytes <= r_page_bytes * r_pages_per_block;
        r_dev_bytes   <= r_block_bytes * r_block_count;
    end

    // Input register: range checks happen here, before the divider chains.
    logic            r_s0_valid;
    logic [31:0]     r_s0_addr;
    ntac_pkg::t_side r_s0_side;
    ntac_pkg::t_side n_s0_side;
    logic            s0_ready;
    logic [31:0]     in_addr;
    logic [31:0]     in_size;
    logic [43:0]     end_bytes;
    logic            c1_ready;

    assign in_addr   = cmd.byte_address & AMASK;
    assign in_size   = cmd.byte_count & AMASK;
    assign end_bytes = {12'd0, in_addr} + {12'd0, in_size};
    assign s0_ready  = !r_s0_valid || c1_ready;
    assign cmd.ready = s0_ready;

    always_comb begin
        n_s0_side               = '0;
        n_s0_side.action        = cmd.action;
        n_s0_side.rw_range_ok   = ({12'd0, in_size} <= r_dev_bytes) && (end_bytes <= r_dev_bytes);
        n_s0_side.er_range_ok   = {12'd0, in_addr} < r_dev_bytes;
        n_s0_side.size_zero     = in_size == '0;
        n_s0_side.size          = in_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && cmd.valid) begin
            r_s0_addr <= in_addr;
            r_s0_side <= n_s0_side;
        end
    end

    // Chain one: address by page size gives the page and its alignment.
    logic            c1_valid;
    logic [31:0]     c1_quo;
    logic [16:0]     c1_rem;
    ntac_pkg::t_side c1_side;
    ntac_pkg::t_side c2_in_side;
    logic            c2_ready;

    ntac_div_chain #(.W(ntac_pkg::WORD_BITS), .D(17), .SW(SW)) u_div_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s0_valid),
        .o_ready   (c1_ready),
        .i_num     (r_s0_addr),
        .i_side    (r_s0_side),
        .i_divisor (r_page_bytes),
        .o_valid   (c1_valid),
        .i_ready   (c2_ready),
        .o_quo     (c1_quo),
        .o_rem     (c1_rem),
        .o_side    (c1_side)
    );

    always_comb begin
        c2_in_side              = c1_side;
        c2_in_side.page         = c1_quo;
        c2_in_side.addr_aligned = c1_rem == '0;
    end

    // Chain two: byte count by page size gives the page total.
    logic            c2_valid;
    logic [31:0]     c2_quo;
    logic [16:0]     c2_rem;
    ntac_pkg::t_side c2_side;
    ntac_pkg::t_side c3_in_side;
    logic            c3_ready;

    ntac_div_chain #(.W(ntac_pkg::WORD_BITS), .D(17), .SW(SW)) u_div_size (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c1_valid),
        .o_ready   (c2_ready),
        .i_num     (c1_side.size),
        .i_side    (c2_in_side),
        .i_divisor (r_page_bytes),
        .o_valid   (c2_valid),
        .i_ready   (c3_ready),
        .o_quo     (c2_quo),
        .o_rem     (c2_rem),
        .o_side    (c2_side)
    );

    always_comb begin
        c3_in_side              = c2_side;
        c3_in_side.total        = c2_quo;
        c3_in_side.size_aligned = c2_rem == '0;
    end

    // Chain three: page by pages per block gives the block and page in block.
    logic            c3_valid;
    logic [31:0]     c3_quo;
    logic [10:0]     c3_rem;
    ntac_pkg::t_side c3_side;
    ntac_pkg::t_side c4_in_side;
    logic            c4_ready;

    ntac_div_chain #(.W(ntac_pkg::WORD_BITS), .D(11), .SW(SW)) u_div_page (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c2_valid),
        .o_ready   (c3_ready),
        .i_num     (c2_side.page),
        .i_side    (c3_in_side),
        .i_divisor (r_pages_per_block),
        .o_valid   (c3_valid),
        .i_ready   (c4_ready),
        .o_quo     (c3_quo),
        .o_rem     (c3_rem),
        .o_side    (c3_side)
    );

    // Erase rounds down to its block, which is the same quotient with the
    // page in block forced to zero later on.
    always_comb begin
        c4_in_side               = c3_side;
        c4_in_side.page_in_block = c3_rem[9:0];
        c4_in_side.block_ok      = c3_quo < {16'd0, r_block_count};
    end

    // Chain four: block by blocks per plane gives the plane and block in plane.
    logic            c4_valid;
    logic [31:0]     c4_quo;
    logic [15:0]     c4_rem;
    ntac_pkg::t_side c4_side;
    logic            out_ready;

    ntac_div_chain #(.W(ntac_pkg::WORD_BITS), .D(16), .SW(SW)) u_div_block (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c3_valid),
        .o_ready   (c4_ready),
        .i_num     (c3_quo),
        .i_side    (c4_in_side),
        .i_divisor (r_blocks_per_plane),
        .o_valid   (c4_valid),
        .i_ready   (out_ready),
        .o_quo     (c4_quo),
        .o_rem     (c4_rem),
        .o_side    (c4_side)
    );

    // Final decision and output register.
    logic        geo_ok;
    logic        plane_ok;
    logic        is_rw;
    logic        cmd_ok;
    logic [1:0]  n_err;
    logic        r_res_valid;
    logic        r_accepted;
    logic [1:0]  r_error_code;
    logic [9:0]  r_page_in_block;
    logic [15:0] r_block_in_plane;
    logic [3:0]  r_plane_index;
    logic [31:0] r_page_total;

    assign geo_ok   = (r_page_bytes != '0) && (r_pages_per_block != '0)
                      && (r_blocks_per_plane != '0);
    assign plane_ok = c4_quo < {27'd0, r_plane_count};
    assign is_rw    = (c4_side.action == ntac_pkg::ACT_READ)
                      || (c4_side.action == ntac_pkg::ACT_WRITE);

    always_comb begin
        case (c4_side.action)
            ntac_pkg::ACT_READ, ntac_pkg::ACT_WRITE: begin
                cmd_ok = geo_ok && !c4_side.size_zero && c4_side.size_aligned
                         && c4_side.rw_range_ok && c4_side.addr_aligned
                         && c4_side.block_ok && plane_ok;
            end
            ntac_pkg::ACT_ERASE: begin
                cmd_ok = geo_ok && c4_side.er_range_ok && c4_side.block_ok && plane_ok;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
        if (!r_device_ready) begin
            n_err = ntac_pkg::ERR_NOT_READY;
        end else if (!cmd_ok) begin
            n_err = ntac_pkg::ERR_BAD_PARAM;
        end else begin
            n_err = ntac_pkg::ERR_NONE;
        end
    end

    assign out_ready = !r_res_valid || res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (out_ready) begin
            r_res_valid <= c4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && c4_valid) begin
            r_accepted   <= n_err == ntac_pkg::ERR_NONE;
            r_error_code <= n_err;
            if (n_err == ntac_pkg::ERR_NONE) begin
                r_page_in_block  <= is_rw ? c4_side.page_in_block : '0;
                r_block_in_plane <= c4_rem;
                r_plane_index    <= c4_quo[3:0];
                r_page_total     <= is_rw ? c4_side.total : '0;
            end else begin
                r_page_in_block  <= '0;
                r_block_in_plane <= '0;
                r_plane_index    <= '0;
                r_page_total     <= '0;
            end
        end
    end

    assign res.valid          = r_res_valid;
    assign res.accepted       = r_accepted;
    assign res.error_code     = r_error_code;
    assign res.page_in_block  = r_page_in_block;
    assign res.block_in_plane = r_block_in_plane;
    assign res.plane_index    = r_plane_index;
    assign res.page_total     = r_page_total;

    // A result is accepted exactly when it carries no error.
    a_accept_matches_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (res.accepted == (res.error_code == ntac_pkg::ERR_NONE)))
        else $error("accepted flag disagrees with error code");

    // A rejected command reports no translated address.
    a_reject_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && !res.accepted) |-> (res.page_total == '0 && res.page_in_block == '0
            && res.block_in_plane == '0 && res.plane_index == '0))
        else $error("rejected result carries address fields");

    // The pipeline is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !res.valid)
        else $error("result valid right after reset");

    // An erase never reports a page count.
    a_erase_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ready && c4_valid && c4_side.action == ntac_pkg::ACT_ERASE)
            |=> (res.page_total == '0 && res.page_in_block == '0))
        else $error("erase result carries a page count");

endmodule

`default_nettype wire

// File: hdl/ntac_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step: takes the top dividend bit into the partial
// remainder and shifts one quotient bit in at the bottom.
module ntac_div_cell #(
    parameter int unsigned W  = 32,
    parameter int unsigned D  = 17,
    parameter int unsigned SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [W-1:0]  i_nq,
    input  wire logic [D-1:0]  i_rem,
    input  wire logic [SW-1:0] i_side,
    input  wire logic [D-1:0]  i_divisor,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [W-1:0]       o_nq,
    output logic [D-1:0]       o_rem,
    output logic [SW-1:0]      o_side
);
    logic          r_valid;
    logic [W-1:0]  r_nq;
    logic [D-1:0]  r_rem;
    logic [SW-1:0] r_side;
    logic [D:0]    shifted;
    logic [D:0]    diff;
    logic          ge;

    assign shifted = {i_rem, i_nq[W-1]};
    assign diff    = shifted - {1'b0, i_divisor};
    assign ge      = shifted >= {1'b0, i_divisor};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_nq   <= {i_nq[W-2:0], ge};
            r_rem  <= ge ? diff[D-1:0] : shifted[D-1:0];
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_nq    = r_nq;
    assign o_rem   = r_rem;
    assign o_side  = r_side;
endmodule

`default_nettype wire

// File: hdl/ntac_div_chain.sv
`timescale 1ns / 1ps
`default_nettype none

// W division cells in a row; the quotient and remainder leave the last one.
module ntac_div_chain #(
    parameter int unsigned W  = 32,
    parameter int unsigned D  = 17,
    parameter int unsigned SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [SW-1:0] i_side,
    input  wire logic [D-1:0]  i_divisor,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [W-1:0]       o_quo,
    output logic [D-1:0]       o_rem,
    output logic [SW-1:0]      o_side
);
    logic          v   [0:W];
    logic          rdy [0:W];
    logic [W-1:0]  nq  [0:W];
    logic [D-1:0]  rem [0:W];
    logic [SW-1:0] sd  [0:W];

    assign v[0]    = i_valid;
    assign nq[0]   = i_num;
    assign rem[0]  = '0;
    assign sd[0]   = i_side;
    assign o_ready = rdy[0];
    assign rdy[W]  = i_ready;

    for (genvar k = 0; k < W; k++) begin : g_cell
        ntac_div_cell #(.W(W), .D(D), .SW(SW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (v[k]),
            .o_ready   (rdy[k]),
            .i_nq      (nq[k]),
            .i_rem     (rem[k]),
            .i_side    (sd[k]),
            .i_divisor (i_divisor),
            .o_valid   (v[k+1]),
            .i_ready   (rdy[k+1]),
            .o_nq      (nq[k+1]),
            .o_rem     (rem[k+1]),
            .o_side    (sd[k+1])
        );
    end

    assign o_valid = v[W];
    assign o_quo   = nq[W];
    assign o_rem   = rem[W];
    assign o_side  = sd[W];
endmodule

`default_nettype wire

// File: sim/nand_addr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Watches the command and result channels, predicts each result from the
// current geometry and compares it field by field.
module nand_addr_checker #(
    parameter int unsigned ADDRESS_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire logic        i_cmd_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_byte_address,
    input  wire logic [31:0] i_byte_count,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic        i_accepted,
    input  wire logic [1:0]  i_error_code,
    input  wire logic [9:0]  i_page_in_block,
    input  wire logic [15:0] i_block_in_plane,
    input  wire logic [3:0]  i_plane_index,
    input  wire logic [31:0] i_page_total,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic        accepted;
        logic [1:0]  error_code;
        logic [9:0]  page_in_block;
        logic [15:0] block_in_plane;
        logic [3:0]  plane_index;
        logic [31:0] page_total;
    } t_translation;

    logic [16:0] geo_page_bytes;
    logic [10:0] geo_pages_per_block;
    logic [15:0] geo_blocks_per_plane;
    logic [15:0] geo_block_count;
    logic [4:0]  geo_plane_count;
    logic        geo_ready;

    t_translation expected_translations[$];

    assign o_pending = expected_translations.size();

    // Splits a page-start address; returns 0 when it is misaligned, out of range or a geometry field is zero.
    function automatic bit split_page_address(input logic [63:0] addr,
                                              output logic [63:0] pg,
                                              output logic [63:0] blk,
                                              output logic [63:0] pl);
        logic [63:0] page_no, block_no, plane_no;
        pg = 0; blk = 0; pl = 0;
        if (geo_page_bytes == 0 || geo_pages_per_block == 0 || geo_blocks_per_plane == 0)
            return 0;
        if (addr % geo_page_bytes != 0) return 0;
        page_no  = addr / geo_page_bytes;
        block_no = page_no / geo_pages_per_block;
        plane_no = block_no / geo_blocks_per_plane;
        if (block_no >= geo_block_count || plane_no >= geo_plane_count) return 0;
        pg  = page_no % geo_pages_per_block;
        blk = block_no % geo_blocks_per_plane;
        pl  = plane_no;
        return 1;
    endfunction

    function automatic t_translation translate_command(input logic [1:0] act,
                                                       input logic [31:0] a,
                                                       input logic [31:0] c);
        logic [63:0] amask, addr, size, dev, blk_bytes, pg, blk, pl, total;
        logic [1:0]  err;
        t_translation t;
        amask = (64'd1 << ADDRESS_BITS) - 1;
        addr  = {32'd0, a} & amask;
        size  = {32'd0, c} & amask;
        dev   = 64'(geo_page_bytes) * geo_pages_per_block * geo_block_count;
        pg = 0; blk = 0; pl = 0; total = 0;
        err = ntac_pkg::ERR_NONE;
        if (!geo_ready) begin
            err = ntac_pkg::ERR_NOT_READY;
        end else if (act == ntac_pkg::ACT_READ || act == ntac_pkg::ACT_WRITE) begin
            if (geo_page_bytes == 0 || size == 0 || size % geo_page_bytes != 0)
                err = ntac_pkg::ERR_BAD_PARAM;
            else if (size > dev || addr > dev - size)
                err = ntac_pkg::ERR_BAD_PARAM;
            else if (!split_page_address(addr, pg, blk, pl))
                err = ntac_pkg::ERR_BAD_PARAM;
            else
                total = size / geo_page_bytes;
        end else if (act == ntac_pkg::ACT_ERASE) begin
            blk_bytes = 64'(geo_page_bytes) * geo_pages_per_block;
            if (blk_bytes == 0 || addr >= dev)
                err = ntac_pkg::ERR_BAD_PARAM;
            else if (!split_page_address(addr - addr % blk_bytes, pg, blk, pl))
                err = ntac_pkg::ERR_BAD_PARAM;
        end else begin
            err = ntac_pkg::ERR_BAD_PARAM;
        end
        if (err != ntac_pkg::ERR_NONE) begin
            pg = 0; blk = 0; pl = 0; total = 0;
        end
        t.accepted       = (err == ntac_pkg::ERR_NONE);
        t.error_code     = err;
        t.page_in_block  = pg[9:0];
        t.block_in_plane = blk[15:0];
        t.plane_index    = pl[3:0];
        t.page_total     = total[31:0];
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_translation want;
        if (!i_rst_n) begin
            o_fail_count          = 0;
            geo_page_bytes       <= '0;
            geo_pages_per_block  <= '0;
            geo_blocks_per_plane <= '0;
            geo_block_count      <= '0;
            geo_plane_count      <= '0;
            geo_ready            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ntac_pkg::CFG_PAGE_BYTES:       geo_page_bytes       <= i_cfg_data;
                    ntac_pkg::CFG_PAGES_PER_BLOCK:  geo_pages_per_block  <= i_cfg_data[10:0];
                    ntac_pkg::CFG_BLOCKS_PER_PLANE: geo_blocks_per_plane <= i_cfg_data[15:0];
                    ntac_pkg::CFG_BLOCK_COUNT:      geo_block_count      <= i_cfg_data[15:0];
                    ntac_pkg::CFG_PLANE_COUNT:      geo_plane_count      <= i_cfg_data[4:0];
                    ntac_pkg::CFG_DEVICE_READY:     geo_ready            <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready)
                expected_translations.push_back(
                    translate_command(i_action, i_byte_address, i_byte_count));
            if (i_res_valid && i_res_ready) begin
                if (expected_translations.size() == 0) begin
                    $display("%0t: result transfer with no command waiting", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_translations.pop_front();
                    if (i_accepted !== want.accepted)
                        report_mismatch("accepted", i_accepted, want.accepted);
                    if (i_error_code !== want.error_code)
                        report_mismatch("error_code", i_error_code, want.error_code);
                    if (i_page_in_block !== want.page_in_block)
                        report_mismatch("page_in_block", i_page_in_block, want.page_in_block);
                    if (i_block_in_plane !== want.block_in_plane)
                        report_mismatch("block_in_plane", i_block_in_plane,
                                        want.block_in_plane);
                    if (i_plane_index !== want.plane_index)
                        report_mismatch("plane_index", i_plane_index, want.plane_index);
                    if (i_page_total !== want.page_total)
                        report_mismatch("page_total", i_page_total, want.page_total);
                end
            end
        end
    end
endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
`default_nettype none

// Drives read, write and erase commands into the NAND address check under a
// series of geometries, while a separate checker predicts every result. The
// geometry changes only once the pipeline has drained, and both the command
// side and the result side pause at random.
module tb;
    localparam int unsigned LATENCY = 130;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    int          fail_count;
    int          pending;

    // Mirror of the geometry, used only to aim addresses and counts at the device.
    int unsigned cur_page_bytes, cur_ppb, cur_blocks;

    ntac_cmd_if cmd ();
    ntac_res_if res ();

    nand_transfer_address_check #(.ADDRESS_BITS(32)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cmd         (cmd.sink),
        .res         (res.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    nand_addr_checker #(.ADDRESS_BITS(32)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd.valid),
        .i_cmd_ready      (cmd.ready),
        .i_action         (cmd.action),
        .i_byte_address   (cmd.byte_address),
        .i_byte_count     (cmd.byte_count),
        .i_res_valid      (res.valid),
        .i_res_ready      (res.ready),
        .i_accepted       (res.accepted),
        .i_error_code     (res.error_code),
        .i_page_in_block  (res.page_in_block),
        .i_block_in_plane (res.block_in_plane),
        .i_plane_index    (res.plane_index),
        .i_page_total     (res.page_total),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pause_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // The result side stalls at random; some phases run with no stall at all.
    bit sink_stalls;
    initial begin
        int unsigned sink_gap;
        res.ready = 1'b0;
        sink_stalls = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!sink_stalls) begin
                res.ready <= 1'b1;
            end else if ($urandom_range(99) < 70) begin
                res.ready <= 1'b1;
            end else begin
                sink_gap = pause_length();
                if (sink_gap != 0) begin
                    res.ready <= 1'b0;
                    repeat (sink_gap) @(posedge i_clk);
                end
                res.ready <= 1'b1;
            end
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [16:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned pb, input int unsigned ppb,
                                input int unsigned bpp, input int unsigned blocks,
                                input int unsigned planes, input bit ready);
        write_register(ntac_pkg::CFG_PAGE_BYTES, pb[16:0]);
        write_register(ntac_pkg::CFG_PAGES_PER_BLOCK, ppb[16:0]);
        write_register(ntac_pkg::CFG_BLOCKS_PER_PLANE, bpp[16:0]);
        write_register(ntac_pkg::CFG_BLOCK_COUNT, blocks[16:0]);
        write_register(ntac_pkg::CFG_PLANE_COUNT, planes[16:0]);
        write_register(ntac_pkg::CFG_DEVICE_READY, {16'd0, ready});
        // Wait for the device size product to settle.
        repeat (4) @(posedge i_clk);
        cur_page_bytes = pb;
        cur_ppb        = ppb;
        cur_blocks     = blocks;
    endtask

    // Sends one command and holds it until the block takes the transfer.
    task automatic send_command(input logic [1:0] act, input logic [31:0] addr,
                                input logic [31:0] count);
        int unsigned gap;
        gap = pause_length();
        if (gap != 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd.valid        <= 1'b1;
        cmd.action       <= act;
        cmd.byte_address <= addr;
        cmd.byte_count   <= count;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        cmd.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // A page-aligned address inside the device most of the time, raw otherwise.
    function automatic logic [31:0] pick_address();
        longint unsigned dev_pages, pg;
        dev_pages = longint'(cur_ppb) * cur_blocks;
        if (cur_page_bytes == 0 || dev_pages == 0 || $urandom_range(9) == 0)
            return $urandom();
        pg = $urandom_range(9) < 2 ? dev_pages - 1 - $urandom_range(2)
                                   : {$urandom(), $urandom()} % dev_pages;
        if (pg >= dev_pages) pg = 0;
        return 32'(pg * cur_page_bytes + ($urandom_range(9) == 0 ? $urandom_range(3, 1) : 0));
    endfunction

    function automatic logic [31:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0) return 32'd0;
        if (roll == 1) return $urandom();
        if (roll == 2) return 32'(cur_page_bytes * $urandom_range(3) + 1);
        return 32'(cur_page_bytes * (roll < 15 ? $urandom_range(4, 1) : $urandom_range(300, 1)));
    endfunction

    task automatic random_commands(input int unsigned n);
        logic [1:0] act;
        repeat (n) begin
            act = $urandom_range(19) == 0 ? 2'd3 : 2'($urandom_range(2));
            send_command(act, pick_address(), pick_count());
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        cmd.valid        = 1'b0;
        cmd.action       = ntac_pkg::ACT_READ;
        cmd.byte_address = '0;
        cmd.byte_count   = '0;
        cur_page_bytes   = 0;
        cur_ppb          = 0;
        cur_blocks       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset the device is not ready for any action.
        send_command(ntac_pkg::ACT_READ, 32'd0, 32'd512);
        send_command(ntac_pkg::ACT_ERASE, 32'hFFFF_FFFF, 32'd0);
        send_command(2'd3, 32'd0, 32'd0);
        drain_pipeline();

        // Small ordinary geometry: extremes of each field, misalignment, range ends.
        set_geometry(512, 4, 3, 10, 4, 1'b1);
        send_command(ntac_pkg::ACT_READ, 32'd0, 32'd512);
        send_command(ntac_pkg::ACT_WRITE, 32'd512 * 39, 32'd512);
        send_command(ntac_pkg::ACT_WRITE, 32'd512 * 39, 32'd1024);
        send_command(ntac_pkg::ACT_READ, 32'd0, 32'd512 * 40);
        send_command(ntac_pkg::ACT_READ, 32'd0, 32'd0);
        send_command(ntac_pkg::ACT_READ, 32'd1, 32'd512);
        send_command(ntac_pkg::ACT_READ, 32'd0, 32'd513);
        send_command(ntac_pkg::ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(ntac_pkg::ACT_ERASE, 32'd512 * 13 + 7, 32'hFFFF_FFFF);
        send_command(ntac_pkg::ACT_ERASE, 32'd512 * 40 - 1, 32'd0);
        send_command(ntac_pkg::ACT_ERASE, 32'd512 * 40, 32'd0);
        send_command(2'd3, 32'd0, 32'd512);
        drain_pipeline();

        // Planes fewer than the blocks need: upper blocks fall outside.
        set_geometry(512, 4, 3, 10, 2, 1'b1);
        send_command(ntac_pkg::ACT_READ, 32'd512 * 4 * 6, 32'd512);
        send_command(ntac_pkg::ACT_ERASE, 32'd512 * 4 * 5, 32'd0);
        random_commands(40);
        drain_pipeline();

        // Zero in each geometry register rejects everything.
        set_geometry(0, 4, 3, 10, 4, 1'b1);
        random_commands(8);
        drain_pipeline();
        set_geometry(512, 0, 3, 10, 4, 1'b1);
        random_commands(8);
        drain_pipeline();
        set_geometry(512, 4, 0, 10, 4, 1'b1);
        random_commands(8);
        drain_pipeline();
        set_geometry(512, 4, 3, 0, 4, 1'b1);
        random_commands(8);
        drain_pipeline();
        set_geometry(512, 4, 3, 10, 0, 1'b1);
        random_commands(8);
        drain_pipeline();

        // Large geometry: the device size exceeds 32 bits.
        sink_stalls = 1'b0;
        set_geometry(65536, 1024, 65535, 65535, 16, 1'b1);
        send_command(ntac_pkg::ACT_READ, 32'hFFFF_0000, 32'd65536);
        send_command(ntac_pkg::ACT_WRITE, 32'd0, 32'hFFFF_0000);
        send_command(ntac_pkg::ACT_ERASE, 32'hFFFF_FFFF, 32'd0);
        random_commands(80);
        drain_pipeline();
        sink_stalls = 1'b1;

        // Oversized fields: pages per block and plane count beyond their ranges.
        set_geometry(2048, 2047, 5, 300, 31, 1'b1);
        random_commands(60);
        drain_pipeline();

        // Odd page sizes and single-block planes.
        set_geometry(1000, 7, 1, 16, 16, 1'b1);
        random_commands(100);
        drain_pipeline();

        set_geometry(4096, 64, 512, 1024, 2, 1'b1);
        random_commands(150);
        drain_pipeline();

        set_geometry(131071, 1, 65535, 1, 1, 1'b1);
        random_commands(30);
        drain_pipeline();

        set_geometry(2, 1024, 8, 65535, 16, 1'b1);
        random_commands(120);
        drain_pipeline();

        // Readiness withdrawn again.
        set_geometry(512, 4, 3, 10, 4, 1'b0);
        random_commands(20);
        drain_pipeline();

        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
